@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, opcodes and types of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_BITS = 12;
  localparam int MAX_PAGES = 1 << PAGE_BITS;
  localparam int TOP_ORDER = 12;
  localparam int ORD_W     = 4;
  localparam int LINK_W    = PAGE_BITS + 1;
  localparam int NUM_LISTS = TOP_ORDER + 1;
  localparam int SIZE_W    = 25;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_PAGES);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // per-page values written by the initialize sweep
  typedef struct packed {
    logic [ORD_W-1:0] ord;
    logic             fre;
  } init_val_t;

endpackage

@@ rtl/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 4
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  logic              we,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/bpa_init_gen.sv @@
// ----------------------------------------------------------------------------
// bpa_init_gen
// Order and free mark that one page holds after freeing pages 0..N-1 in turn.
// ----------------------------------------------------------------------------
module bpa_init_gen (
  input  logic [bpa_pkg::PAGE_BITS-1:0] page,
  input  logic [bpa_pkg::LINK_W-1:0]    pool_n,
  output bpa_pkg::init_val_t            val
);

  logic [bpa_pkg::LINK_W:0]   sum;
  logic [bpa_pkg::LINK_W-1:0] mask;
  logic [bpa_pkg::LINK_W-1:0] head;

  // A page heads an order t block while its low t+1 bits are clear and the
  // block fits; the largest such t is the last order stored there.
  always_comb begin
    val  = '0;
    sum  = '0;
    mask = '0;
    head = '0;
    for (int t = 0; t <= bpa_pkg::TOP_ORDER; t++) begin
      mask = bpa_pkg::LINK_W'((2 << t) - 1);
      sum  = (bpa_pkg::LINK_W+1)'(page) + (bpa_pkg::LINK_W+1)'(1 << t);
      if ((({1'b0, page} & mask) == '0) && (sum <= {1'b0, pool_n})) begin
        val.ord = bpa_pkg::ORD_W'(t);
      end
      head = pool_n & ~mask;
      if (pool_n[t] && (head == {1'b0, page})) begin
        val.fre = 1'b1;
      end
    end
  end

endmodule

@@ rtl/buddy_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator: per-page order, free mark and list links in RAM,
// walked by a sequencer one memory access step at a time.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_opcode, in_size_bytes, in_page_index
//  out      output     out_valid / out_stall out_status, out_alloc_page
//  cfg      input      cfg_valid / cfg_ready cfg_pool_pages
//
//  Allocate: unlinks the head of the first fitting list, then splits one level per step; a failed one ends at once.
//  Free: reads the page, then merges with a free buddy one level per step before the push.
//  Initialize: one RAM row per cycle over all pages.
//  After reset a clearing sweep over all pages runs; in_stall stays high meanwhile.
//  One request is in work at a time; a held result does not block accepting the next, but that one waits in S_DONE.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [24:0] in_size_bytes,
  input  logic [11:0] in_page_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [11:0] out_alloc_page,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_pool_pages
);

  localparam int PB = bpa_pkg::PAGE_BITS;
  localparam int LW = bpa_pkg::LINK_W;
  localparam int OW = bpa_pkg::ORD_W;
  localparam logic [OW-1:0] TOP = OW'(bpa_pkg::TOP_ORDER);

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_SWEEP   = 13'h0002,
    S_FREE_RD = 13'h0004,
    S_FREE_CK = 13'h0008,
    S_MRG     = 13'h0010,
    S_MRG_CK  = 13'h0020,
    S_ALLOC   = 13'h0040,
    S_SPLIT   = 13'h0080,
    S_UNL_RD  = 13'h0100,
    S_UNL_WR  = 13'h0200,
    S_PUSH0   = 13'h0400,
    S_PUSH1   = 13'h0800,
    S_DONE    = 13'h1000
  } state_t;

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]        op_r;
  logic [24:0]       size_r;
  logic [PB-1:0]     p_r, p_nxt, x_r, x_nxt, b_r, b_nxt, j_r, j_nxt;
  logic [OW-1:0]     o_r, o_nxt, want_r, want_nxt;
  logic [LW-1:0]     head_r [bpa_pkg::NUM_LISTS];
  logic [LW-1:0]     head_nxt [bpa_pkg::NUM_LISTS];
  logic              rst_sweep_r, rst_sweep_nxt;
  logic              status_r, status_nxt;
  logic [PB-1:0]     page_res_r, page_res_nxt;
  logic              out_valid_r;
  logic              out_status_r;
  logic [PB-1:0]     out_page_r;
  logic [12:0]       pool_r;

  logic [LW-1:0]     pool_n, sweep_n;
  bpa_pkg::init_val_t init_val;

  // RAM ports
  logic [PB-1:0] ord_addr, fre_addr, nxt_addr, prv_addr;
  logic          ord_we, fre_we, nxt_we, prv_we;
  logic [OW-1:0] ord_wd, ord_rd;
  logic          fre_wd, fre_rd;
  logic [LW-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;

  // datapath helpers
  logic [LW-1:0] span, b_sum, r_sum, h_cur;
  logic [PB-1:0] b_cur;
  logic [OW-1:0] want_c, found_o, o_dec;
  logic          found;
  logic [25:0]   lim;

  assign pool_n    = (pool_r > LW'(bpa_pkg::MAX_PAGES)) ? LW'(bpa_pkg::MAX_PAGES) : pool_r;
  assign sweep_n   = rst_sweep_r ? '0 : pool_n;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_alloc_page = out_page_r;

  bpa_init_gen u_init (
    .page   (j_r),
    .pool_n (sweep_n),
    .val    (init_val)
  );

  bpa_ram #(.ADDR_W(PB), .DATA_W(OW)) u_ord (
    .clk(clk), .addr(ord_addr), .we(ord_we), .wdata(ord_wd), .rdata(ord_rd));
  bpa_ram #(.ADDR_W(PB), .DATA_W(1)) u_fre (
    .clk(clk), .addr(fre_addr), .we(fre_we), .wdata(fre_wd), .rdata(fre_rd));
  bpa_ram #(.ADDR_W(PB), .DATA_W(LW)) u_nxt (
    .clk(clk), .addr(nxt_addr), .we(nxt_we), .wdata(nxt_wd), .rdata(nxt_rd));
  bpa_ram #(.ADDR_W(PB), .DATA_W(LW)) u_prv (
    .clk(clk), .addr(prv_addr), .we(prv_we), .wdata(prv_wd), .rdata(prv_rd));

  // size to order, and the first non-empty list at or above it
  always_comb begin
    want_c  = OW'(bpa_pkg::TOP_ORDER + 1);
    lim     = '0;
    found   = 1'b0;
    found_o = '0;
    for (int w = bpa_pkg::TOP_ORDER; w >= 0; w--) begin
      lim = 26'(1) << (w + PB);
      if ({1'b0, size_r} <= lim) begin
        want_c = OW'(w);
      end
    end
    for (int o = bpa_pkg::TOP_ORDER; o >= 0; o--) begin
      if ((OW'(o) >= want_c) && (head_r[o] < bpa_pkg::NIL_LINK)) begin
        found   = 1'b1;
        found_o = OW'(o);
      end
    end
  end

  assign span  = LW'(1) << o_r;
  assign b_cur = p_r ^ span[PB-1:0];
  assign b_sum = LW'(b_cur) + span;
  assign o_dec = o_r - OW'(1);
  assign r_sum = LW'(p_r) + (LW'(1) << o_dec);
  assign h_cur = head_r[o_r];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    p_nxt         = p_r;
    x_nxt         = x_r;
    b_nxt         = b_r;
    j_nxt         = j_r;
    o_nxt         = o_r;
    want_nxt      = want_r;
    rst_sweep_nxt = rst_sweep_r;
    status_nxt    = status_r;
    page_res_nxt  = page_res_r;
    head_nxt      = head_r;

    ord_addr = x_r; ord_we = 1'b0; ord_wd = o_r;
    fre_addr = x_r; fre_we = 1'b0; fre_wd = 1'b0;
    nxt_addr = x_r; nxt_we = 1'b0; nxt_wd = bpa_pkg::NIL_LINK;
    prv_addr = x_r; prv_we = 1'b0; prv_wd = bpa_pkg::NIL_LINK;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt   = 1'b0;
          page_res_nxt = '0;
          case (bpa_pkg::op_t'(in_opcode))
            bpa_pkg::OP_ALLOC: state_nxt = S_ALLOC;
            bpa_pkg::OP_FREE: begin
              p_nxt = in_page_index;
              state_nxt = (LW'(in_page_index) >= pool_n) ? S_DONE : S_FREE_RD;
            end
            bpa_pkg::OP_INIT: begin
              j_nxt = '0;
              for (int k = 0; k < bpa_pkg::NUM_LISTS; k++) begin
                head_nxt[k] = pool_n[k] ? (pool_n & ~LW'((2 << k) - 1))
                                        : bpa_pkg::NIL_LINK;
              end
              state_nxt = S_SWEEP;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        ord_addr = j_r; ord_we = 1'b1; ord_wd = init_val.ord;
        fre_addr = j_r; fre_we = 1'b1; fre_wd = init_val.fre;
        nxt_addr = j_r; nxt_we = 1'b1;
        prv_addr = j_r; prv_we = 1'b1;
        j_nxt = j_r + PB'(1);
        if (j_r == PB'(bpa_pkg::MAX_PAGES - 1)) begin
          state_nxt     = rst_sweep_r ? S_IDLE : S_DONE;
          rst_sweep_nxt = 1'b0;
        end
      end
      S_FREE_RD: begin
        ord_addr = p_r;
        fre_addr = p_r;
        state_nxt = S_FREE_CK;
      end
      S_FREE_CK: begin
        if (fre_rd) begin
          state_nxt = S_DONE;
        end else begin
          o_nxt = (ord_rd > TOP) ? TOP : ord_rd;
          state_nxt = S_MRG;
        end
      end
      S_MRG: begin
        ord_addr = b_cur;
        fre_addr = b_cur;
        b_nxt    = b_cur;
        if ((o_r >= TOP) || (b_sum > pool_n)) begin
          x_nxt = p_r; ret_nxt = S_DONE; state_nxt = S_PUSH0;
        end else begin
          state_nxt = S_MRG_CK;
        end
      end
      S_MRG_CK: begin
        if (!fre_rd || (ord_rd != o_r)) begin
          x_nxt = p_r; ret_nxt = S_DONE; state_nxt = S_PUSH0;
        end else begin
          // absorb the buddy, keep the lower page
          x_nxt = b_r;
          p_nxt = (b_r < p_r) ? b_r : p_r;
          o_nxt = o_r + OW'(1);
          ret_nxt = S_MRG;
          state_nxt = S_UNL_RD;
        end
      end
      S_ALLOC: begin
        if ((want_c > TOP) || !found) begin
          status_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          p_nxt    = head_r[found_o][PB-1:0];
          x_nxt    = head_r[found_o][PB-1:0];
          o_nxt    = found_o;
          want_nxt = want_c;
          ret_nxt  = S_SPLIT;
          state_nxt = S_UNL_RD;
        end
      end
      S_SPLIT: begin
        ord_addr = p_r;
        ord_we   = 1'b1;
        if (o_r > want_r) begin
          ord_wd = o_dec;
          o_nxt  = o_dec;
          if (r_sum < bpa_pkg::NIL_LINK) begin
            x_nxt = r_sum[PB-1:0]; ret_nxt = S_SPLIT; state_nxt = S_PUSH0;
          end
        end else begin
          ord_wd = want_r;
          page_res_nxt = p_r;
          state_nxt = S_DONE;
        end
      end
      S_UNL_RD: begin
        ord_addr = x_r;
        nxt_addr = x_r;
        prv_addr = x_r;
        state_nxt = S_UNL_WR;
      end
      S_UNL_WR: begin
        if (prv_rd < bpa_pkg::NIL_LINK) begin
          nxt_addr = prv_rd[PB-1:0]; nxt_we = 1'b1; nxt_wd = nxt_rd;
        end else if (ord_rd <= TOP) begin
          head_nxt[ord_rd] = nxt_rd;
        end
        if (nxt_rd < bpa_pkg::NIL_LINK) begin
          prv_addr = nxt_rd[PB-1:0]; prv_we = 1'b1; prv_wd = prv_rd;
        end
        fre_addr = x_r; fre_we = 1'b1; fre_wd = 1'b0;
        state_nxt = ret_r;
      end
      S_PUSH0: begin
        nxt_we = 1'b1; nxt_wd = h_cur;
        prv_we = 1'b1; prv_wd = bpa_pkg::NIL_LINK;
        ord_we = 1'b1; ord_wd = o_r;
        fre_we = 1'b1; fre_wd = 1'b1;
        state_nxt = S_PUSH1;
      end
      S_PUSH1: begin
        if (h_cur < bpa_pkg::NIL_LINK) begin
          prv_addr = h_cur[PB-1:0]; prv_we = 1'b1; prv_wd = LW'(x_r);
        end
        head_nxt[o_r] = LW'(x_r);
        state_nxt = ret_r;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      ret_r       <= S_IDLE;
      rst_sweep_r <= 1'b1;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      pool_r      <= 13'(bpa_pkg::MAX_PAGES);
      for (int k = 0; k < bpa_pkg::NUM_LISTS; k++) begin
        head_r[k] <= bpa_pkg::NIL_LINK;
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      rst_sweep_r <= rst_sweep_nxt;
      j_r         <= j_nxt;
      head_r      <= head_nxt;
      if (cfg_valid && cfg_ready) begin
        pool_r <= cfg_pool_pages;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_opcode;
      size_r <= in_size_bytes;
    end
    p_r        <= p_nxt;
    x_r        <= x_nxt;
    b_r        <= b_nxt;
    o_r        <= o_nxt;
    want_r     <= want_nxt;
    status_r   <= status_nxt;
    page_res_r <= page_res_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_status_r <= status_r;
      out_page_r   <= (op_r == 2'(bpa_pkg::OP_ALLOC) && !status_r) ? page_res_r : '0;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_page_r == '0)
    else $error("failed allocation returned a page");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH0 |-> o_r <= TOP)
    else $error("push above top order");

  a_split_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |-> o_r >= want_r)
    else $error("split went below requested order");

  a_merge_top: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MRG_CK |-> o_r < TOP)
    else $error("merge check at top order");

endmodule

@@ verif/buddy_page_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit_test
// Self-checking bench for the buddy page allocator. A behavioral allocator
// model predicts the status and page of every accepted request; results are
// compared in order. Directed cases come first, then random request streams
// over several pool sizes with random idling on both channels.
// ----------------------------------------------------------------------------

typedef struct {
  logic        status;
  logic [11:0] page;
} alloc_answer_t;

class alloc_scoreboard;
  logic [3:0]    order_of [bpa_pkg::MAX_PAGES];
  bit            is_free  [bpa_pkg::MAX_PAGES];
  int            next_blk [bpa_pkg::MAX_PAGES];
  int            prev_blk [bpa_pkg::MAX_PAGES];
  int            head     [bpa_pkg::NUM_LISTS];
  int            pool_reg;
  int            errors;
  alloc_answer_t answers[$];
  int            live[$];

  function new();
    pool_reg = bpa_pkg::MAX_PAGES;
    errors   = 0;
    wipe();
  endfunction

  function void wipe();
    for (int i = 0; i < bpa_pkg::MAX_PAGES; i++) begin
      order_of[i] = '0;
      is_free[i]  = 0;
      next_blk[i] = bpa_pkg::MAX_PAGES;
      prev_blk[i] = bpa_pkg::MAX_PAGES;
    end
    for (int o = 0; o < bpa_pkg::NUM_LISTS; o++) head[o] = bpa_pkg::MAX_PAGES;
    live.delete();
  endfunction

  function int pages();
    return (pool_reg > bpa_pkg::MAX_PAGES) ? bpa_pkg::MAX_PAGES : pool_reg;
  endfunction

  function void push(int p, int o);
    int h;
    if (p >= bpa_pkg::MAX_PAGES || o > bpa_pkg::TOP_ORDER) return;
    h = head[o];
    next_blk[p] = h;
    prev_blk[p] = bpa_pkg::MAX_PAGES;
    if (h < bpa_pkg::MAX_PAGES) prev_blk[h] = p;
    head[o] = p;
    order_of[p] = 4'(o);
    is_free[p] = 1;
  endfunction

  function void unlink(int p);
    int o, nx, pv;
    o  = int'(order_of[p]);
    nx = next_blk[p];
    pv = prev_blk[p];
    if (pv < bpa_pkg::MAX_PAGES) next_blk[pv] = nx;
    else if (o <= bpa_pkg::TOP_ORDER) head[o] = nx;
    if (nx < bpa_pkg::MAX_PAGES) prev_blk[nx] = pv;
    is_free[p] = 0;
  endfunction

  function void release_page(int p);
    int n, o, b, span;
    n = pages();
    if (p >= n || is_free[p]) return;
    o = int'(order_of[p]);
    if (o > bpa_pkg::TOP_ORDER) o = bpa_pkg::TOP_ORDER;
    while (o < bpa_pkg::TOP_ORDER) begin
      span = 1 << o;
      b = p ^ span;
      if (b + span > n) break;
      if (!is_free[b] || int'(order_of[b]) != o) break;
      unlink(b);
      if (b < p) p = b;
      o++;
    end
    push(p, o);
  endfunction

  function bit grab(longint size, output int page);
    int want, o, p, r;
    want = 0;
    page = 0;
    if (size > (64'd1 << bpa_pkg::PAGE_BITS))
      while (want <= bpa_pkg::TOP_ORDER &&
             (64'd1 << (want + bpa_pkg::PAGE_BITS)) < size) want++;
    if (want > bpa_pkg::TOP_ORDER) return 1;
    p = bpa_pkg::MAX_PAGES;
    for (o = want; o <= bpa_pkg::TOP_ORDER; o++) begin
      p = head[o];
      if (p < bpa_pkg::MAX_PAGES) break;
    end
    if (o > bpa_pkg::TOP_ORDER) return 1;
    unlink(p);
    while (o > want) begin
      o--;
      r = p + (1 << o);
      order_of[p] = 4'(o);
      if (r < bpa_pkg::MAX_PAGES) push(r, o);
    end
    order_of[p] = 4'(want);
    page = p;
    return 0;
  endfunction

  function void note_request(bpa_pkg::op_t op, logic [24:0] size, logic [11:0] idx);
    alloc_answer_t a;
    int pg;
    a.status = 0;
    a.page   = 0;
    case (op)
      bpa_pkg::OP_ALLOC: begin
        a.status = grab(longint'(size), pg);
        if (!a.status) begin
          a.page = 12'(pg);
          live.push_back(pg);
        end
      end
      bpa_pkg::OP_FREE: release_page(int'(idx));
      bpa_pkg::OP_INIT: begin
        wipe();
        for (int i = 0; i < pages(); i++) release_page(i);
      end
      default: ;
    endcase
    answers.push_back(a);
  endfunction

  function void check_result(logic status, logic [11:0] page);
    alloc_answer_t a;
    if (answers.size() == 0) begin
      $error("unexpected result: status %0d page %0d", status, page);
      errors++;
      return;
    end
    a = answers.pop_front();
    if (status !== a.status) begin
      $error("status: expected %0d, got %0d", a.status, status);
      errors++;
    end
    if (page !== a.page) begin
      $error("alloc_page: expected %0d, got %0d", a.page, page);
      errors++;
    end
  endfunction
endclass

module buddy_page_allocator_unit_test;
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [24:0] in_size_bytes;
  logic [11:0] in_page_index;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [11:0] out_alloc_page;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_pool_pages;

  alloc_scoreboard sb = new();
  int  sent = 0;
  bit  calm;
  bit  held = 0;

  buddy_page_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_size_bytes(in_size_bytes), .in_page_index(in_page_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_alloc_page(out_alloc_page),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_pages(cfg_pool_pages)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign calm = (sent >= 450 && sent < 600);

  task automatic send_request(bpa_pkg::op_t op, logic [24:0] size, logic [11:0] idx);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_size_bytes <= size;
    in_page_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, size, idx);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_pool(logic [12:0] v);
    cfg_valid      <= 1'b1;
    cfg_pool_pages <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.pool_reg = int'(v);
  endtask

  // size in bytes for a block of the given order
  function automatic logic [24:0] bytes_for(int k);
    if (k == 0) return 25'($urandom_range(0, 4096));
    return 25'($urandom_range((4096 << (k - 1)) + 1, 4096 << k));
  endfunction

  task automatic random_request();
    int r, k, pg;
    r = $urandom_range(99);
    if (r < 45) begin
      k = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
      send_request(bpa_pkg::OP_ALLOC, bytes_for(k), 12'($urandom));
    end else if (r < 85 && sb.live.size() != 0) begin
      k  = $urandom_range(sb.live.size() - 1);
      pg = sb.live[k];
      sb.live.delete(k);
      // now and then free a page one to three pages past the block's head instead
      if ($urandom_range(9) == 0) pg = (pg + $urandom_range(1, 3)) & 12'hFFF;
      send_request(bpa_pkg::OP_FREE, 25'($urandom), 12'(pg));
    end else if (r < 95) begin
      send_request(bpa_pkg::OP_FREE, 25'($urandom), 12'($urandom));
    end else if (r < 97) begin
      send_request(bpa_pkg::OP_ALLOC, 25'($urandom_range(0, 25'h1FFFFFF)), 12'($urandom));
    end else if (r < 99) begin
      send_request(bpa_pkg::OP_NONE, 25'($urandom), 12'($urandom));
    end else begin
      send_request(bpa_pkg::OP_INIT, 25'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    logic [12:0] pools[5];
    pools          = '{13'd37, 13'd1, 13'd8191, 13'd300, 13'd4096};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = bpa_pkg::OP_NONE;
    in_size_bytes  = '0;
    in_page_index  = '0;
    cfg_valid      = 1'b0;
    cfg_pool_pages = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pool, unknown opcode, sizes at the edges, double and
    // interior frees
    send_request(bpa_pkg::OP_ALLOC, 25'd0, 12'd0);
    send_request(bpa_pkg::OP_NONE, 25'h1FFFFFF, 12'hFFF);
    send_request(bpa_pkg::OP_INIT, 25'd0, 12'd0);
    send_request(bpa_pkg::OP_ALLOC, 25'd0, 12'd0);
    send_request(bpa_pkg::OP_ALLOC, 25'd4096, 12'd0);
    send_request(bpa_pkg::OP_ALLOC, 25'd4097, 12'd0);
    send_request(bpa_pkg::OP_ALLOC, 25'h1000000, 12'd0);
    send_request(bpa_pkg::OP_ALLOC, 25'h1000001, 12'd0);
    send_request(bpa_pkg::OP_ALLOC, 25'h1FFFFFF, 12'd0);
    send_request(bpa_pkg::OP_FREE, 25'd0, 12'd0);
    send_request(bpa_pkg::OP_FREE, 25'd0, 12'd0);
    send_request(bpa_pkg::OP_FREE, 25'd0, 12'd3);
    send_request(bpa_pkg::OP_FREE, 25'd0, 12'hFFF);
    send_request(bpa_pkg::OP_INIT, 25'd0, 12'd0);
    send_request(bpa_pkg::OP_ALLOC, 25'h1000000, 12'd0);
    send_request(bpa_pkg::OP_FREE, 25'd0, 12'd2048);
    send_request(bpa_pkg::OP_ALLOC, 25'd8192, 12'd0);
    send_request(bpa_pkg::OP_FREE, 25'd0, 12'd0);
    drain();

    foreach (pools[i]) begin
      write_pool(pools[i]);
      send_request(bpa_pkg::OP_INIT, 25'($urandom), 12'($urandom));
      if (pools[i] == 13'd37) send_request(bpa_pkg::OP_FREE, 25'd0, 12'd4095);
      repeat (175) random_request();
      drain();
    end

    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent >= 250) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= (!calm && $urandom_range(99) < 38);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_alloc_page);

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_init_gen.sv
rtl/buddy_page_allocator_unit.sv
verif/buddy_page_allocator_unit_test.sv
